/* sv/double_ended_queue_defines.svh */
// ----------------------------------------------------------------------------
// double_ended_queue_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("double_ended_queue check failed");

// next-cycle implication, disabled in reset
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("double_ended_queue check failed");

`endif

/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// types and constants of the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int WORD_W      = 32;
   localparam int OPCODE_W    = 3;
   localparam int STATUS_W    = 2;
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SIZE       = 3'd4,
      OP_EMPTY      = 3'd5,
      OP_FRONT      = 3'd6,
      OP_BACK       = 3'd7
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // classified command handed from front to back
   typedef struct packed {
      logic              is_push;
      logic              is_read;
      logic              takes;
      logic              at_back;
      logic              is_empty_query;
      logic [WORD_W-1:0] value;
   } cmd_type;

   localparam logic [WORD_W-1:0] WORD_ALL_ONES = {WORD_W{1'b1}};

endpackage

/* sv/double_ended_queue.sv */
// a command is held in the command queue, then any response it gives is registered in the response register
// throughput: one command per cycle while responses are taken, pushes, pops and queries alike
// the back end takes a command each cycle its response register is free
// reset: pointers, count, command queue and response valid cleared
// store contents stay undefined after reset and need no clearing pass
// ----------------------------------------------------------------------------
// double_ended_queue
// ring-buffer deque of signed words with front end, command queue and back end
// ----------------------------------------------------------------------------
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 1024
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OPCODE_W-1:0]       req_opcode,
   input  logic signed [WORD_W-1:0]  req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [WORD_W-1:0]  rsp_data,
   output logic [STATUS_W-1:0]       rsp_status
);

   logic    q_full, q_push, q_pop_valid, q_pop;
   cmd_type q_push_cmd, q_pop_cmd;

   dq_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .req_value  (req_value),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_push_cmd)
   );

   dq_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop_valid (q_pop_valid),
      .pop       (q_pop),
      .pop_cmd   (q_pop_cmd)
   );

   dq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_pop_valid),
      .cmd_ready  (q_pop),
      .cmd        (q_pop_cmd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status)
   );

endmodule

/* sv/dq_front.sv */
// ----------------------------------------------------------------------------
// dq_front
// accepts commands and classifies them for the back end
// ----------------------------------------------------------------------------
module dq_front
   import dq_pkg::*;
(
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [WORD_W-1:0]   req_value,
   input  logic                       q_full,
   output logic                       q_push,
   output cmd_type                    q_cmd
);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd                = '0;
      q_cmd.value          = req_value;
      case (opcode_type'(req_opcode))
         OP_PUSH_BACK: begin
            q_cmd.is_push = 1'b1;
            q_cmd.at_back = 1'b1;
         end
         OP_PUSH_FRONT: begin
            q_cmd.is_push = 1'b1;
         end
         OP_POP_FRONT: begin
            q_cmd.is_read = 1'b1;
            q_cmd.takes   = 1'b1;
         end
         OP_POP_BACK: begin
            q_cmd.is_read = 1'b1;
            q_cmd.takes   = 1'b1;
            q_cmd.at_back = 1'b1;
         end
         OP_SIZE: begin
            q_cmd.is_push = 1'b0;
         end
         OP_EMPTY: begin
            q_cmd.is_empty_query = 1'b1;
         end
         OP_FRONT: begin
            q_cmd.is_read = 1'b1;
         end
         OP_BACK: begin
            q_cmd.is_read = 1'b1;
            q_cmd.at_back = 1'b1;
         end
         default: begin
            q_cmd.is_read = 1'b1;
            q_cmd.at_back = 1'b1;
         end
      endcase
   end

endmodule

/* sv/dq_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// dq_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module dq_cmd_fifo
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop,
   output cmd_type pop_cmd
);

   cmd_type                 entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                    do_pop;

   assign full      = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* sv/dq_back.sv */
// ----------------------------------------------------------------------------
// dq_back
// executes commands on the ring store and holds the response register
// ----------------------------------------------------------------------------
module dq_back
   import dq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 1024
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  cmd_type                   cmd,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [WORD_W-1:0]  rsp_data,
   output logic [STATUS_W-1:0]       rsp_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   logic [WORD_W-1:0]  store_mem [QUEUE_DEPTH];

   logic [PTR_W-1:0]   front_ff, front_in;
   logic [PTR_W-1:0]   back_ff, back_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff;
   status_type         rsp_status_ff;

   logic [PTR_W-1:0]   front_next, front_prev, back_next, back_prev;
   logic               is_empty, is_full, fire;
   logic               wr_en, rd_en, load;
   logic [PTR_W-1:0]   wr_addr, rd_addr;
   logic [WORD_W-1:0]  imm_data;
   status_type         imm_status;

   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == DEPTH_CNT);
   assign front_next = (front_ff == LAST_PTR) ? '0 : front_ff + 1'b1;
   assign front_prev = (front_ff == '0) ? LAST_PTR : front_ff - 1'b1;
   assign back_next  = (back_ff == LAST_PTR) ? '0 : back_ff + 1'b1;
   assign back_prev  = (back_ff == '0) ? LAST_PTR : back_ff - 1'b1;

   assign cmd_ready  = !rsp_valid_ff || rsp_ready;
   assign fire       = cmd_valid && cmd_ready;

   always_comb begin
      front_in     = front_ff;
      back_in      = back_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      load         = 1'b0;
      wr_addr      = back_ff;
      rd_addr      = front_ff;
      imm_data     = WORD_W'(count_ff);
      imm_status   = STATUS_OK;
      if (fire) begin
         if (cmd.is_push) begin
            if (is_full) begin
               load       = 1'b1;
               imm_data   = '0;
               imm_status = STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (cmd.at_back) begin
                  wr_addr = back_ff;
                  back_in = back_next;
               end else begin
                  wr_addr  = front_prev;
                  front_in = front_prev;
               end
            end
         end else if (cmd.is_read) begin
            load = 1'b1;
            if (is_empty) begin
               imm_data   = WORD_ALL_ONES;
               imm_status = STATUS_EMPTY;
            end else begin
               rd_en   = 1'b1;
               rd_addr = cmd.at_back ? back_prev : front_ff;
               if (cmd.takes) begin
                  count_in = count_ff - 1'b1;
                  if (cmd.at_back) begin
                     back_in = back_prev;
                  end else begin
                     front_in = front_next;
                  end
               end
            end
         end else if (cmd.is_empty_query) begin
            load     = 1'b1;
            imm_data = WORD_W'(is_empty);
         end else begin
            load = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= cmd.value;
      end
   end

   // store read is registered directly in the response register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff   <= rd_en ? store_mem[rd_addr] : imm_data;
         rsp_status_ff <= imm_status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;

endmodule

/* sv/dq_checker.sv */
// ----------------------------------------------------------------------------
// dq_checker
// port-level checks of the response channel
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module dq_checker
   import dq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [WORD_W-1:0]  rsp_data,
   input  logic [STATUS_W-1:0]       rsp_status
);

   // stalled response holds
   `DQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data) && $stable(rsp_status))

   `DQ_ASSERT_NOW(a_status_legal, clock, reset, rsp_valid, rsp_status == STATUS_OK || rsp_status == STATUS_EMPTY || rsp_status == STATUS_FULL)

   // empty status always carries all ones
   `DQ_ASSERT_NOW(a_empty_data, clock, reset, rsp_valid && rsp_status == STATUS_EMPTY, rsp_data == WORD_ALL_ONES)

   // dropped push carries zero
   `DQ_ASSERT_NOW(a_full_data, clock, reset, rsp_valid && rsp_status == STATUS_FULL, rsp_data == '0)

   `DQ_ASSERT_NOW(a_reset_idle, clock, reset, $past(reset), !rsp_valid)

endmodule

bind double_ended_queue dq_checker u_checker (.*);

/* bench/double_ended_queue_checker.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// watches the command and response channels of the deque, keeps its own
// ring of words with head, tail and count, and compares every response
// transfer field by field with the oldest predicted response
// ----------------------------------------------------------------------------
module double_ended_queue_checker
   import dq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 1024
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [OPCODE_W-1:0]       req_opcode,
   input  logic signed [WORD_W-1:0]  req_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [WORD_W-1:0]  rsp_data,
   input  logic [STATUS_W-1:0]       rsp_status,
   output int                        failures,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [WORD_W-1:0] data;
      status_type               status;
   } response_type;

   logic signed [WORD_W-1:0] word_ring [QUEUE_DEPTH];
   int unsigned              head_index = 0;
   int unsigned              tail_index = 0;
   int unsigned              word_total = 0;
   response_type             awaited_responses [$];

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   task automatic apply_command(input opcode_type op, input logic signed [WORD_W-1:0] val);
      response_type resp;
      bit           gives;
      gives       = 1'b1;
      resp.data   = '0;
      resp.status = STATUS_OK;
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (word_total == QUEUE_DEPTH) begin
               resp.status = STATUS_FULL;
            end else begin
               gives = 1'b0;
               if (op == OP_PUSH_BACK) begin
                  word_ring[tail_index] = val;
                  tail_index = (tail_index + 1) % QUEUE_DEPTH;
               end else begin
                  head_index = (head_index + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                  word_ring[head_index] = val;
               end
               word_total++;
            end
         end
         OP_SIZE: begin
            resp.data = word_total;
         end
         OP_EMPTY: begin
            resp.data = (word_total == 0) ? 1 : 0;
         end
         default: begin
            if (word_total == 0) begin
               resp.data   = WORD_ALL_ONES;
               resp.status = STATUS_EMPTY;
            end else begin
               case (op)
                  OP_POP_FRONT: begin
                     resp.data  = word_ring[head_index];
                     head_index = (head_index + 1) % QUEUE_DEPTH;
                     word_total--;
                  end
                  OP_POP_BACK: begin
                     tail_index = (tail_index + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                     resp.data  = word_ring[tail_index];
                     word_total--;
                  end
                  OP_FRONT: begin
                     resp.data = word_ring[head_index];
                  end
                  default: begin
                     resp.data = word_ring[(tail_index + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                  end
               endcase
            end
         end
      endcase
      if (gives) begin
         awaited_responses = {awaited_responses, resp};
      end
   endtask

   always @(posedge clock) begin : monitor
      response_type want;
      if (reset) begin
         head_index = 0;
         tail_index = 0;
         word_total = 0;
         awaited_responses.delete();
      end else begin
         if (req_valid && req_ready) begin
            apply_command(opcode_type'(req_opcode), req_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_responses.size() == 0) begin
               $error("unexpected response transfer: data %0d, status %0d",
                      rsp_data, rsp_status);
               failures++;
            end else begin
               want = awaited_responses[0];
               awaited_responses.delete(0);
               if (rsp_data !== want.data) begin
                  $error("data: expected %0d, actual %0d", want.data, rsp_data);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  failures++;
               end
            end
         end
      end
      outstanding = awaited_responses.size();
   end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives commands into the deque under several idle and stall mixes: a
// directed pass over empty, peek and pop corner cases, random mixes of
// pushes, pops and queries, and a push burst followed by a pop burst
// ----------------------------------------------------------------------------
module testbench;
   import dq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH    = 1024;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int PHASE_ITEMS    = 220;
   localparam int BURST_ITEMS    = 24;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_valid  = 1'b0;
   logic                      req_ready;
   logic [OPCODE_W-1:0]       req_opcode = OP_SIZE;
   logic signed [WORD_W-1:0]  req_value  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready  = 1'b0;
   logic signed [WORD_W-1:0]  rsp_data;
   logic [STATUS_W-1:0]       rsp_status;

   int failures;
   int outstanding;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;

   double_ended_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status)
   );

   double_ended_queue_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .rsp_status  (rsp_status),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // entered and left at a falling edge
   task automatic send_command(input opcode_type op, input logic signed [WORD_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic run_random(input int count, input int push_share);
      opcode_type op;
      int         roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            op = opcode_type'($urandom_range(7));
         end else if (roll < 10 + push_share) begin
            op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end else if (roll < 80) begin
            op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
         end else begin
            op = opcode_type'(OP_SIZE + $urandom_range(3));
         end
         send_command(op, $urandom());
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty queue, then max at front, min at back, front pointer wrap
      send_command(OP_POP_FRONT, '0);
      send_command(OP_POP_BACK, '0);
      send_command(OP_FRONT, '0);
      send_command(OP_BACK, '0);
      send_command(OP_SIZE, '0);
      send_command(OP_EMPTY, '0);
      send_command(OP_PUSH_FRONT, 32'sh7fffffff);
      send_command(OP_PUSH_BACK, 32'sh80000000);
      send_command(OP_PUSH_BACK, '0);
      send_command(OP_PUSH_FRONT, -32'sd1);
      send_command(OP_FRONT, '0);
      send_command(OP_BACK, '0);
      send_command(OP_SIZE, '0);
      send_command(OP_EMPTY, '0);
      send_command(OP_POP_FRONT, '0);
      send_command(OP_POP_BACK, '0);
      send_command(OP_POP_BACK, '0);
      send_command(OP_POP_FRONT, '0);
      send_command(OP_POP_FRONT, '0);
      send_command(OP_SIZE, '0);
      send_command(OP_EMPTY, '0);
      wait_for_drain();
      @(negedge clock);

      send_idle_pct = 0;  recv_stall_pct = 0;
      run_random(PHASE_ITEMS, 42);
      wait_for_drain();
      @(negedge clock);

      send_idle_pct = 56; recv_stall_pct = 0;
      run_random(PHASE_ITEMS, 42);
      wait_for_drain();
      @(negedge clock);

      send_idle_pct = 0;  recv_stall_pct = 56;
      run_random(PHASE_ITEMS, 30);
      wait_for_drain();
      @(negedge clock);

      send_idle_pct = 6;  recv_stall_pct = 6;
      run_random(PHASE_ITEMS, 36);

      // push burst, query both ends, then pop burst
      for (int i = 0; i < BURST_ITEMS; i++) begin
         send_command($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom());
      end
      send_command(OP_SIZE, '0);
      send_command(OP_EMPTY, '0);
      send_command(OP_FRONT, '0);
      send_command(OP_BACK, '0);
      for (int i = 0; i < BURST_ITEMS; i++) begin
         send_command($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, '0);
      end
      send_command(OP_EMPTY, '0);
      send_command(OP_SIZE, '0);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
